// File: design/lsss_pkg.sv
package lsss_pkg;

   localparam int SampleWidth  = 12;
   localparam int StepWidth    = 6;
   localparam int LedCount     = 5;
   localparam int ChanWidth    = 4;
   localparam int IndexWidth   = 4;
   localparam int SensorCount  = 8;

   localparam logic [LedCount-1:0]  LedsOff     = '1;
   localparam logic [StepWidth-1:0] LastSensor  = 6'd31;
   localparam logic [StepWidth-1:0] StepCurrent = 6'd32;
   localparam logic [StepWidth-1:0] StepVoltage = 6'd33;
   localparam logic [StepWidth-1:0] LastStep    = 6'd34;

   localparam logic [ChanWidth-1:0] ChRestart   = 4'd0;
   localparam logic [ChanWidth-1:0] ChTopSensor = 4'd7;
   localparam logic [ChanWidth-1:0] ChCurrent   = 4'd8;
   localparam logic [ChanWidth-1:0] ChVoltage   = 4'd9;
   localparam logic [ChanWidth-1:0] ChCharge    = 4'd10;

   localparam logic [IndexWidth-1:0] IdxNone    = 4'd0;
   localparam logic [IndexWidth-1:0] IdxCurrent = 4'd8;
   localparam logic [IndexWidth-1:0] IdxVoltage = 4'd9;
   localparam logic [IndexWidth-1:0] IdxCharge  = 4'd10;

   typedef enum logic [1:0] {
      PH_SETTLE_DARK  = 2'd0,
      PH_READ_DARK    = 2'd1,
      PH_SETTLE_LIT   = 2'd2,
      PH_READ_LIT     = 2'd3
   } phase_type;

   typedef struct packed {
      logic [StepWidth-1:0]   scan_step;
      logic [SampleWidth-1:0] dark_level;
      logic [LedCount-1:0]    led_pattern;
   } state_type;

   typedef struct packed {
      logic [ChanWidth-1:0]   next_channel;
      logic [LedCount-1:0]    led_drive_n;
      logic                   value_valid;
      logic [IndexWidth-1:0]  value_index;
      logic [SampleWidth-1:0] value;
   } result_type;

   typedef logic [2:0] led_num_type;

   function automatic led_num_type sensor_led(input logic [2:0] sensor);
      led_num_type led;
      unique case (sensor)
         3'd0:         led = 3'd4;
         3'd1, 3'd2:   led = 3'd3;
         3'd3, 3'd4:   led = 3'd2;
         3'd5, 3'd6:   led = 3'd1;
         default:      led = 3'd0;
      endcase
      return led;
   endfunction

endpackage

// File: design/lsss_if.sv
interface lsss_req_if;
   logic                              valid;
   logic                              ready;
   logic [lsss_pkg::SampleWidth-1:0]  sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface lsss_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lsss_pkg::ChanWidth-1:0]    next_channel;
   logic [lsss_pkg::LedCount-1:0]     led_drive_n;
   logic                              value_valid;
   logic [lsss_pkg::IndexWidth-1:0]   value_index;
   logic [lsss_pkg::SampleWidth-1:0]  value;

   modport source (output valid, output next_channel, output led_drive_n,
                   output value_valid, output value_index, output value,
                   input ready);
   modport sink   (input valid, input next_channel, input led_drive_n,
                   input value_valid, input value_index, input value,
                   output ready);
endinterface

// File: design/lsss_step.sv
module lsss_step (
   input  lsss_pkg::state_type                   state_cur,
   input  logic [lsss_pkg::SampleWidth-1:0]      sample,
   output lsss_pkg::state_type                   state_nxt,
   output lsss_pkg::result_type                  result
);
   import lsss_pkg::*;

   logic [StepWidth-1:0] step;
   logic [2:0]           sensor;
   phase_type            phase;
   led_num_type          led;
   logic [StepWidth-1:0] step_inc;
   logic [ChanWidth-1:0] sensor_chan;
   logic [SampleWidth-1:0] lit_minus_dark;

   assign step           = state_cur.scan_step;
   assign sensor         = step[4:2];
   assign phase          = phase_type'(step[1:0]);
   assign led            = sensor_led(sensor);
   assign step_inc       = step + 6'd1;
   assign sensor_chan    = ChTopSensor - {1'b0, step_inc[5:3]};
   assign lit_minus_dark = (sample > state_cur.dark_level) ?
                           (sample - state_cur.dark_level) : '0;

   always_comb begin
      state_nxt          = state_cur;
      result             = '0;
      result.value_index = IdxNone;
      if (step <= LastSensor) begin
         unique case (phase)
            PH_SETTLE_DARK: begin
               if (step == '0) begin
                  state_nxt.led_pattern = LedsOff;
               end
            end
            PH_READ_DARK: begin
               state_nxt.dark_level  = sample;
               state_nxt.led_pattern = state_cur.led_pattern
                                       & ~(LedCount'(1) << led);
            end
            PH_SETTLE_LIT: begin
            end
            PH_READ_LIT: begin
               state_nxt.led_pattern = LedsOff;
               result.value_valid    = 1'b1;
               result.value_index    = {1'b0, sensor};
               result.value          = lit_minus_dark;
            end
            default: begin
            end
         endcase
         result.next_channel = (step == LastSensor) ? ChCurrent : sensor_chan;
         state_nxt.scan_step = step_inc;
      end else begin
         unique case (step)
            StepCurrent: begin
               result.value_valid  = 1'b1;
               result.value_index  = IdxCurrent;
               result.value        = sample;
               result.next_channel = ChVoltage;
               state_nxt.scan_step = StepVoltage;
            end
            StepVoltage: begin
               result.value_valid  = 1'b1;
               result.value_index  = IdxVoltage;
               result.value        = sample;
               result.next_channel = ChCharge;
               state_nxt.scan_step = LastStep;
            end
            LastStep: begin
               result.value_valid    = 1'b1;
               result.value_index    = IdxCharge;
               result.value          = sample;
               result.next_channel   = ChRestart;
               state_nxt.led_pattern = LedsOff;
               state_nxt.scan_step   = '0;
            end
            default: begin
               result.next_channel   = ChRestart;
               state_nxt.led_pattern = LedsOff;
               state_nxt.scan_step   = '0;
            end
         endcase
      end
      result.led_drive_n = state_nxt.led_pattern;
   end

endmodule

// File: design/line_sensor_scan_sequencer_unit.sv
// Line sensor scan sequencer.
// req_ch carries one finished converter sample per transfer; rsp_ch returns
// exactly one result per sample: the converter channel to sample next, the
// active-low drive of the five infrared LEDs, and any measurement captured.
// A scan runs 35 steps: four per line sensor (settle, dark read that turns one LED
// on, settle, bright read giving bright minus dark floored at zero), then
// current, voltage and charge status. A step outside the scan restarts it.
// Latency: the result of a sample is presented in the cycle after its
// transfer, from the result register.
// Throughput: one sample per cycle unless rsp_ch stalls; the step logic is a
// table lookup and one 12-bit subtract between state and result registers.
// Stall: while a result waits on rsp_ch, req_ch stays ready only when the
// receiver takes that result in the same cycle, so the result register
// holds until it is transferred.
// Reset (synchronous): scan restarts at step 0, dark level 0, LEDs off,
// result register empty.
module line_sensor_scan_sequencer_unit #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   lsss_req_if.sink    req_ch,
   lsss_rsp_if.source  rsp_ch
);
   import lsss_pkg::*;

   localparam int UsedBits = (SAMPLE_BITS < SampleWidth) ? SAMPLE_BITS : SampleWidth;
   localparam logic [SampleWidth-1:0] SampleMask = SampleWidth'((64'd1 << UsedBits) - 64'd1);

   state_type  state_ff;
   state_type  state_in;
   result_type rsp_ff;
   result_type rsp_in;
   logic       rsp_valid_ff;
   logic       accept;
   logic [SampleWidth-1:0] sample_used;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign sample_used  = req_ch.sample & SampleMask;

   lsss_step u_step (
      .state_cur (state_ff),
      .sample    (sample_used),
      .state_nxt (state_in),
      .result    (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.scan_step   <= '0;
         state_ff.dark_level  <= '0;
         state_ff.led_pattern <= LedsOff;
         rsp_valid_ff         <= 1'b0;
      end else begin
         if (accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.next_channel = rsp_ff.next_channel;
   assign rsp_ch.led_drive_n  = rsp_ff.led_drive_n;
   assign rsp_ch.value_valid  = rsp_ff.value_valid;
   assign rsp_ch.value_index  = rsp_ff.value_index;
   assign rsp_ch.value        = rsp_ff.value;

endmodule

// File: design/lsss_checker.sv
module lsss_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [lsss_pkg::ChanWidth-1:0]    rsp_next_channel,
   input logic [lsss_pkg::LedCount-1:0]     rsp_led_drive_n,
   input logic                              rsp_value_valid,
   input logic [lsss_pkg::IndexWidth-1:0]   rsp_value_index,
   input logic [lsss_pkg::SampleWidth-1:0]  rsp_value
);
   import lsss_pkg::*;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result presented straight after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_channel)
         && $stable(rsp_led_drive_n) && $stable(rsp_value_valid)
         && $stable(rsp_value_index) && $stable(rsp_value))
      else $error("stalled result changed");

   a_no_capture_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_value_valid |-> rsp_value_index == IdxNone && rsp_value == '0)
      else $error("value fields set without a capture");

   a_current_then_voltage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_value_valid && rsp_value_index == IdxCurrent
         |-> rsp_next_channel == ChVoltage)
      else $error("current capture not followed by voltage channel");

   a_restart_leds_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_next_channel == ChRestart |-> rsp_led_drive_n == LedsOff)
      else $error("scan restart with an LED driven");

endmodule

bind line_sensor_scan_sequencer_unit lsss_checker u_lsss_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_next_channel (rsp_ch.next_channel),
   .rsp_led_drive_n  (rsp_ch.led_drive_n),
   .rsp_value_valid  (rsp_ch.value_valid),
   .rsp_value_index  (rsp_ch.value_index),
   .rsp_value        (rsp_ch.value)
);

// File: tb/sv/line_sensor_scan_sequencer_unit_tb.sv
module line_sensor_scan_sequencer_unit_tb;
   import lsss_pkg::*;

   localparam int DirectedRows  = 20;
   localparam int RandomSamples = 1880;
   localparam int QuietTail     = 300;
   localparam int WatchdogLimit = 2000;

   typedef struct {
      logic [SampleWidth-1:0] smp;
      bit                     fixed;
      result_type             want;
   } scan_row_type;

   logic clock = 1'b0;
   logic reset;

   lsss_req_if req_ch ();
   lsss_rsp_if rsp_ch ();

   line_sensor_scan_sequencer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #10 clock = ~clock;

   logic [StepWidth-1:0]   scan_pos;
   logic [SampleWidth-1:0] dark_hold;
   logic [LedCount-1:0]    led_mask;

   result_type outstanding_results[$];
   bit         row_fixed;
   result_type row_want;
   bit         quiet;
   int         stall_left;
   int         idle_cycles;
   int         mismatch_count;
   int         samples_sent;
   int         results_seen;
   int         sensor_captures;
   int         floored_captures;
   int         scans_done;
   logic [SampleWidth-1:0] last_smp;
   logic [SampleWidth-1:0] prior_smp;
   scan_row_type rows[DirectedRows];

   function automatic result_type scan_result(input logic [ChanWidth-1:0] chan,
                                              input logic [LedCount-1:0] leds,
                                              input logic vv,
                                              input logic [IndexWidth-1:0] idx,
                                              input logic [SampleWidth-1:0] val);
      result_type r;
      r.next_channel = chan;
      r.led_drive_n  = leds;
      r.value_valid  = vv;
      r.value_index  = idx;
      r.value        = val;
      return r;
   endfunction

   function automatic result_type advance_scan(input logic [SampleWidth-1:0] smp);
      result_type r;
      logic [2:0] k;
      logic [2:0] led;
      phase_type  ph;
      r = '0;
      if (scan_pos <= LastSensor) begin
         k   = scan_pos[4:2];
         ph  = phase_type'(scan_pos[1:0]);
         led = 3'(4 - (int'(k) + 1) / 2);
         if (scan_pos == '0) begin
            led_mask = LedsOff;
         end
         if (ph == PH_READ_DARK) begin
            dark_hold = smp;
            led_mask &= ~(LedCount'(1) << led);
         end
         if (ph == PH_READ_LIT) begin
            led_mask      = LedsOff;
            r.value_valid = 1'b1;
            r.value_index = IndexWidth'(k);
            r.value       = (smp > dark_hold) ? smp - dark_hold : '0;
         end
         r.next_channel = (scan_pos == LastSensor) ? ChCurrent
                        : ChTopSensor - ChanWidth'((int'(scan_pos) + 1) / 8);
         scan_pos = scan_pos + 1'b1;
      end else if (scan_pos == StepCurrent) begin
         r.value_valid  = 1'b1;
         r.value_index  = IdxCurrent;
         r.value        = smp;
         r.next_channel = ChVoltage;
         scan_pos       = StepVoltage;
      end else if (scan_pos == StepVoltage) begin
         r.value_valid  = 1'b1;
         r.value_index  = IdxVoltage;
         r.value        = smp;
         r.next_channel = ChCharge;
         scan_pos       = LastStep;
      end else if (scan_pos == LastStep) begin
         r.value_valid  = 1'b1;
         r.value_index  = IdxCharge;
         r.value        = smp;
         led_mask       = LedsOff;
         r.next_channel = ChRestart;
         scan_pos       = '0;
      end else begin
         led_mask       = LedsOff;
         r.next_channel = ChRestart;
         scan_pos       = '0;
      end
      r.led_drive_n = led_mask;
      return r;
   endfunction

   task automatic log_mismatch(input string what);
      $display("MISMATCH: %s", what);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want) begin
         log_mismatch($sformatf("result %0d field %s: got %0d, want %0d",
                                results_seen, name, got, want));
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         scan_pos  = '0;
         dark_hold = '0;
         led_mask  = LedsOff;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (outstanding_results.size() == 0) begin
               log_mismatch($sformatf("result %0d arrived with nothing pending",
                                      results_seen));
            end else begin
               want = outstanding_results.pop_front();
               compare_field("next_channel", rsp_ch.next_channel, want.next_channel);
               compare_field("led_drive_n", rsp_ch.led_drive_n, want.led_drive_n);
               compare_field("value_valid", rsp_ch.value_valid, want.value_valid);
               compare_field("value_index", rsp_ch.value_index, want.value_index);
               compare_field("value", rsp_ch.value, want.value);
               if (want.value_valid && want.value_index < IdxCurrent) begin
                  sensor_captures++;
                  if (want.value == '0) floored_captures++;
               end
               if (want.value_valid && want.value_index == IdxCharge) scans_done++;
            end
            results_seen++;
         end
         if (req_ch.valid && req_ch.ready) begin
            want = advance_scan(req_ch.sample);
            outstanding_results.push_back(row_fixed ? row_want : want);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 9);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
         $display("Watchdog expired after %0d idle cycles", WatchdogLimit);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_sample(input logic [SampleWidth-1:0] smp, input bit fixed,
                              input result_type want);
      req_ch.valid  <= 1'b1;
      req_ch.sample <= smp;
      row_fixed     <= fixed;
      row_want      <= want;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      prior_smp = last_smp;
      last_smp  = smp;
      samples_sent++;
   endtask

   task automatic sender_gap(input int cycles);
      req_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [SampleWidth-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return prior_smp;
         3:       return prior_smp + SampleWidth'($urandom_range(0, 4)) - SampleWidth'(2);
         default: return SampleWidth'($urandom_range(0, 4095));
      endcase
   endfunction

   initial begin
      int i;
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.sample = '0;
      rsp_ch.ready  = 1'b0;
      row_fixed     = 1'b0;
      row_want      = '0;
      quiet         = 1'b0;
      last_smp      = '0;
      prior_smp     = '0;

      rows = '{
         '{12'hABC, 1'b1, scan_result(ChTopSensor, LedsOff, 1'b0, IdxNone, 12'd0)},
         '{12'hFFF, 1'b1, scan_result(ChTopSensor, 5'h0F, 1'b0, IdxNone, 12'd0)},
         '{12'h000, 1'b1, scan_result(ChTopSensor, 5'h0F, 1'b0, IdxNone, 12'd0)},
         '{12'h000, 1'b1, scan_result(ChTopSensor, LedsOff, 1'b1, 4'd0, 12'd0)},
         '{12'h07B, 1'b1, scan_result(ChTopSensor, LedsOff, 1'b0, IdxNone, 12'd0)},
         '{12'h000, 1'b1, scan_result(ChTopSensor, 5'h17, 1'b0, IdxNone, 12'd0)},
         '{12'h3C3, 1'b1, scan_result(ChTopSensor, 5'h17, 1'b0, IdxNone, 12'd0)},
         '{12'hFFF, 1'b1, scan_result(ChTopSensor - 4'd1, LedsOff, 1'b1, 4'd1, 12'hFFF)},
         '{12'h555, 1'b1, scan_result(ChTopSensor - 4'd1, LedsOff, 1'b0, IdxNone, 12'd0)},
         '{12'h800, 1'b1, scan_result(ChTopSensor - 4'd1, 5'h17, 1'b0, IdxNone, 12'd0)},
         '{12'h7FF, 1'b1, scan_result(ChTopSensor - 4'd1, 5'h17, 1'b0, IdxNone, 12'd0)},
         '{12'h800, 1'b1, scan_result(ChTopSensor - 4'd1, LedsOff, 1'b1, 4'd2, 12'd0)},
         '{12'hAAA, 1'b1, scan_result(ChTopSensor - 4'd1, LedsOff, 1'b0, IdxNone, 12'd0)},
         '{12'h001, 1'b1, scan_result(ChTopSensor - 4'd1, 5'h1B, 1'b0, IdxNone, 12'd0)},
         '{12'h555, 1'b1, scan_result(ChTopSensor - 4'd1, 5'h1B, 1'b0, IdxNone, 12'd0)},
         '{12'h002, 1'b1, scan_result(ChTopSensor - 4'd2, LedsOff, 1'b1, 4'd3, 12'd1)},
         '{12'h0F0, 1'b0, '0},
         '{12'h123, 1'b0, '0},
         '{12'hF0F, 1'b0, '0},
         '{12'h122, 1'b0, '0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DirectedRows; i++) begin
         send_sample(rows[i].smp, rows[i].fixed, rows[i].want);
      end
      drain_results();

      for (i = 0; i < RandomSamples; i++) begin
         quiet = (i >= RandomSamples - QuietTail);
         if (i == RandomSamples / 2) begin
            drain_results();
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            sender_gap($urandom_range(1, 10));
         end
         send_sample(pick_sample(), 1'b0, '0);
      end
      req_ch.valid <= 1'b0;

      while (outstanding_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (outstanding_results.size() != 0) begin
         log_mismatch($sformatf("%0d results never arrived", outstanding_results.size()));
      end

      $display("Sent %0d samples, checked %0d results over %0d complete scans",
               samples_sent, results_seen, scans_done);
      $display("Line sensor readings: %0d, of which %0d floored at zero; %0d mismatches",
               sensor_captures, floored_captures, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
design/lsss_pkg.sv
design/lsss_if.sv
design/lsss_step.sv
design/line_sensor_scan_sequencer_unit.sv
design/lsss_checker.sv
tb/sv/line_sensor_scan_sequencer_unit_tb.sv
